### rtl/core/smeu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared instruction, ALU and status codes, plus the queue entry type.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam logic [3:0] ACT_PUSH   = 4'd0;
    localparam logic [3:0] ACT_LOAD   = 4'd1;
    localparam logic [3:0] ACT_STORE  = 4'd2;
    localparam logic [3:0] ACT_READ   = 4'd3;
    localparam logic [3:0] ACT_WRITE  = 4'd4;
    localparam logic [3:0] ACT_BINOP  = 4'd5;
    localparam logic [3:0] ACT_JUMP   = 4'd6;
    localparam logic [3:0] ACT_JTRUE  = 4'd7;
    localparam logic [3:0] ACT_JFALSE = 4'd8;
    localparam logic [3:0] ACT_END    = 4'd9;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_EQ  = 4'd5;
    localparam logic [3:0] OP_NE  = 4'd6;
    localparam logic [3:0] OP_GT  = 4'd7;
    localparam logic [3:0] OP_LT  = 4'd8;
    localparam logic [3:0] OP_GE  = 4'd9;
    localparam logic [3:0] OP_LE  = 4'd10;
    localparam logic [3:0] OP_OR  = 4'd11;
    localparam logic [3:0] OP_AND = 4'd12;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDEF     = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;
    localparam logic [2:0] ST_ENDED     = 3'd5;
    localparam logic [2:0] ST_STOPPED   = 3'd6;

    // Instruction beat as it travels from the front part to the back part.
    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] operand_value;
        logic [3:0]  var_index;
        logic [3:0]  alu_op;
        logic [7:0]  label_id;
    } instr_t;

endpackage
`default_nettype wire

### rtl/core/smeu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Instruction queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module smeu_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire smeu_pkg::instr_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output smeu_pkg::instr_t      pop_data,
    output logic                  not_empty
);

    smeu_pkg::instr_t mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

### rtl/core/smeu_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative divider
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module smeu_divider
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient,
    output logic [DATA_WIDTH-1:0]      remainder
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH:0]   rem_reg;
    logic [DATA_WIDTH-1:0] dsr_reg;
    logic                  qneg_reg;
    logic                  rneg_reg;
    logic                  done_reg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;

    assign shifted = {rem_reg[DATA_WIDTH-1:0], quo_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign done    = done_reg;
    assign quotient  = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = rneg_reg ? (~rem_reg[DATA_WIDTH-1:0] + 1'b1)
                                : rem_reg[DATA_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
            dsr_reg  <= divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
            rem_reg  <= '0;
            qneg_reg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
            rneg_reg <= dividend[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_WIDTH])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DATA_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/smeu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Execute back part
// Sequencer that owns the operand stack, the variable file and the ALU.
// ----------------------------------------------------------------------------
module smeu_back
#(
    parameter int STACK_DEPTH   = 64,
    parameter int NUM_VARIABLES = 16,
    parameter int DATA_WIDTH    = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire smeu_pkg::instr_t   q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [31:0]             write_value,
    output logic                    write_valid,
    output logic                    branch_taken,
    output logic [7:0]              branch_label,
    output logic [2:0]              status
);

    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int CNW = $clog2(STACK_DEPTH + 1);
    localparam int VIW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_RD2  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] var_mem [NUM_VARIABLES];

    logic [2:0]             state_reg;
    logic [CNW-1:0]         count_reg;
    logic [NUM_VARIABLES-1:0] vvalid_reg;
    logic [1:0]             run_reg;
    smeu_pkg::instr_t       ins_reg;
    logic [DATA_WIDTH-1:0]  b_reg;
    logic [DATA_WIDTH-1:0]  a_reg;
    logic [DATA_WIDTH-1:0]  rd_data_reg;
    logic [DATA_WIDTH-1:0]  var_rd_reg;
    logic [DATA_WIDTH-1:0]  prod_reg;
    logic                   out_valid_reg;
    logic [31:0]            wv_reg;
    logic                   wval_reg;
    logic                   bt_reg;
    logic [7:0]             bl_reg;
    logic [2:0]             st_reg;

    logic [SPW-1:0]         rd_addr;
    logic                   vi_ok;
    logic [VIW-1:0]         vi;
    logic                   div_start;
    logic                   div_done;
    logic [DATA_WIDTH-1:0]  div_q;
    logic [DATA_WIDTH-1:0]  div_r;
    logic [DATA_WIDTH-1:0]  opv;
    logic                   st_we;
    logic [SPW-1:0]         st_addr;
    logic [DATA_WIDTH-1:0]  st_wdata;
    logic [DATA_WIDTH-1:0]  alu_res;
    logic signed [DATA_WIDTH-1:0] sa;
    logic signed [DATA_WIDTH-1:0] sb;

    assign vi    = VIW'(ins_reg.var_index);
    assign vi_ok = ({5'd0, ins_reg.var_index} < 9'(NUM_VARIABLES));
    assign opv   = DATA_WIDTH'($signed(ins_reg.operand_value));
    assign sa    = $signed(a_reg);
    assign sb    = $signed(b_reg);

    assign out_valid    = out_valid_reg;
    assign write_value  = wv_reg;
    assign write_valid  = wval_reg;
    assign branch_taken = bt_reg;
    assign branch_label = bl_reg;
    assign status       = st_reg;
    // The next instruction is taken only once the previous result has left,
    // so the result registers never change under a waiting beat.
    assign q_pop        = (state_reg == S_IDLE) && q_valid && !out_valid_reg;

    always_comb
    begin
        rd_addr = SPW'(count_reg - 1'b1);
        if (state_reg == S_RD1)
        begin
            rd_addr = SPW'(count_reg - 2'd2);
        end
    end

    always_comb
    begin
        alu_res = '0;
        case (ins_reg.alu_op)
            smeu_pkg::OP_ADD: alu_res = a_reg + b_reg;
            smeu_pkg::OP_SUB: alu_res = a_reg - b_reg;
            smeu_pkg::OP_EQ:  alu_res = DATA_WIDTH'(sa == sb);
            smeu_pkg::OP_NE:  alu_res = DATA_WIDTH'(sa != sb);
            smeu_pkg::OP_GT:  alu_res = DATA_WIDTH'(sa > sb);
            smeu_pkg::OP_LT:  alu_res = DATA_WIDTH'(sa < sb);
            smeu_pkg::OP_GE:  alu_res = DATA_WIDTH'(sa >= sb);
            smeu_pkg::OP_LE:  alu_res = DATA_WIDTH'(sa <= sb);
            smeu_pkg::OP_OR:  alu_res = DATA_WIDTH'((a_reg != '0) || (b_reg != '0));
            smeu_pkg::OP_AND: alu_res = DATA_WIDTH'((a_reg != '0) && (b_reg != '0));
            default:          alu_res = '0;
        endcase
    end

    smeu_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Stack and variable memories, one write port each.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= stack_mem[rd_addr];
        var_rd_reg  <= var_mem[vi];
        if (st_we)
        begin
            stack_mem[st_addr] <= st_wdata;
        end
        if ((state_reg == S_EXEC) && (run_reg == 2'd0)
            && (ins_reg.action == smeu_pkg::ACT_STORE) && (count_reg != '0) && vi_ok)
        begin
            var_mem[vi] <= b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD1)
        begin
            b_reg <= rd_data_reg;
        end
        if (state_reg == S_RD2)
        begin
            a_reg <= rd_data_reg;
        end
        if (state_reg == S_EXEC)
        begin
            prod_reg <= a_reg * b_reg;
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        st_we     = 1'b0;
        st_addr   = SPW'(count_reg);
        st_wdata  = opv;
        if ((state_reg == S_EXEC) && (run_reg == 2'd0))
        begin
            case (ins_reg.action)
                smeu_pkg::ACT_PUSH, smeu_pkg::ACT_READ:
                begin
                    st_we = (count_reg < CNW'(STACK_DEPTH));
                end
                smeu_pkg::ACT_LOAD:
                begin
                    st_we    = vi_ok && vvalid_reg[vi] && (count_reg < CNW'(STACK_DEPTH));
                    st_wdata = var_rd_reg;
                end
                smeu_pkg::ACT_BINOP:
                begin
                    st_addr  = SPW'(count_reg - 2'd2);
                    st_wdata = alu_res;
                    if (count_reg >= CNW'(2))
                    begin
                        if (ins_reg.alu_op == smeu_pkg::OP_DIV
                            || ins_reg.alu_op == smeu_pkg::OP_MOD)
                        begin
                            st_we     = 1'b0;
                            div_start = (b_reg != '0) && (b_reg != '1);
                        end
                        else
                        begin
                            st_we = (ins_reg.alu_op != smeu_pkg::OP_MUL);
                        end
                    end
                end
                default:
                begin
                    st_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_MUL)
        begin
            // Multiply, or a divisor of minus one: the product with an
            // all-ones divisor is the negated dividend, and the remainder is 0.
            st_we    = 1'b1;
            st_addr  = SPW'(count_reg - 1'b1);
            st_wdata = (ins_reg.alu_op == smeu_pkg::OP_MOD) ? '0 : prod_reg;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            st_we    = 1'b1;
            st_addr  = SPW'(count_reg - 1'b1);
            st_wdata = (ins_reg.alu_op == smeu_pkg::OP_DIV) ? div_q : div_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            vvalid_reg    <= '0;
            run_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            ins_reg       <= '0;
            wv_reg        <= '0;
            wval_reg      <= 1'b0;
            bt_reg        <= 1'b0;
            bl_reg        <= '0;
            st_reg        <= smeu_pkg::ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        ins_reg   <= q_data;
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                begin
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    wv_reg    <= '0;
                    wval_reg  <= 1'b0;
                    bt_reg    <= 1'b0;
                    bl_reg    <= '0;
                    st_reg    <= smeu_pkg::ST_OK;
                    state_reg <= S_OUT;
                    if (run_reg != 2'd0)
                    begin
                        st_reg <= smeu_pkg::ST_STOPPED;
                    end
                    else
                    begin
                        case (ins_reg.action)
                            smeu_pkg::ACT_PUSH, smeu_pkg::ACT_READ:
                            begin
                                if (count_reg >= CNW'(STACK_DEPTH))
                                begin
                                    st_reg  <= smeu_pkg::ST_OVERFLOW;
                                    run_reg <= 2'd2;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            smeu_pkg::ACT_LOAD:
                            begin
                                if (!vi_ok || !vvalid_reg[vi])
                                begin
                                    st_reg  <= smeu_pkg::ST_UNDEF;
                                    run_reg <= 2'd2;
                                end
                                else if (count_reg >= CNW'(STACK_DEPTH))
                                begin
                                    st_reg  <= smeu_pkg::ST_OVERFLOW;
                                    run_reg <= 2'd2;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            smeu_pkg::ACT_STORE, smeu_pkg::ACT_WRITE,
                            smeu_pkg::ACT_JTRUE, smeu_pkg::ACT_JFALSE:
                            begin
                                if (count_reg == '0)
                                begin
                                    st_reg  <= smeu_pkg::ST_UNDERFLOW;
                                    run_reg <= 2'd2;
                                end
                                else
                                begin
                                    count_reg <= count_reg - 1'b1;
                                    if (ins_reg.action == smeu_pkg::ACT_STORE && vi_ok)
                                    begin
                                        vvalid_reg[vi] <= 1'b1;
                                    end
                                    if (ins_reg.action == smeu_pkg::ACT_WRITE)
                                    begin
                                        wv_reg   <= 32'($signed(b_reg));
                                        wval_reg <= 1'b1;
                                    end
                                    if ((ins_reg.action == smeu_pkg::ACT_JTRUE)
                                        == (b_reg != '0)
                                        && ins_reg.action != smeu_pkg::ACT_STORE
                                        && ins_reg.action != smeu_pkg::ACT_WRITE)
                                    begin
                                        bt_reg <= 1'b1;
                                        bl_reg <= ins_reg.label_id;
                                    end
                                end
                            end
                            smeu_pkg::ACT_BINOP:
                            begin
                                if (count_reg < CNW'(2))
                                begin
                                    st_reg  <= smeu_pkg::ST_UNDERFLOW;
                                    run_reg <= 2'd2;
                                end
                                else if ((ins_reg.alu_op == smeu_pkg::OP_DIV
                                          || ins_reg.alu_op == smeu_pkg::OP_MOD)
                                         && b_reg == '0)
                                begin
                                    st_reg  <= smeu_pkg::ST_DIVZERO;
                                    run_reg <= 2'd2;
                                end
                                else
                                begin
                                    count_reg <= count_reg - 1'b1;
                                    if (ins_reg.alu_op == smeu_pkg::OP_MUL)
                                    begin
                                        state_reg <= S_MUL;
                                    end
                                    else if (ins_reg.alu_op == smeu_pkg::OP_DIV
                                             || ins_reg.alu_op == smeu_pkg::OP_MOD)
                                    begin
                                        if (b_reg == '1)
                                        begin
                                            // Divisor of minus one: negate or zero.
                                            state_reg <= S_MUL;
                                        end
                                        else
                                        begin
                                            state_reg <= S_DIV;
                                        end
                                    end
                                end
                            end
                            smeu_pkg::ACT_JUMP:
                            begin
                                bt_reg <= 1'b1;
                                bl_reg <= ins_reg.label_id;
                            end
                            smeu_pkg::ACT_END:
                            begin
                                st_reg  <= smeu_pkg::ST_ENDED;
                                run_reg <= 2'd1;
                            end
                            default:
                            begin
                                st_reg <= smeu_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_OUT;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/stack_machine_execute_unit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes decoded stack-machine instructions, one result beat per beat in.
// ----------------------------------------------------------------------------
// Each input beat is one decoded instruction and yields exactly one result
// beat carrying a written value, a taken branch, and a status. The front part
// takes beats into a two-entry queue; the back part reads the top two stack
// entries in its RD1 and RD2 states, executes, and parks the result in an
// output register, so a new instruction can queue while a result waits. The
// back part takes its next instruction only after the previous result beat
// has been accepted. Most instructions visit IDLE, RD1, RD2, EXEC and OUT;
// multiply and a minus-one divisor add a MUL state, other divides a DIV
// state that waits for the one-bit-per-cycle divider. After an error or an
// end instruction every further beat answers "stopped earlier" until reset.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_top
#(
    parameter int STACK_DEPTH   = 64,
    parameter int NUM_VARIABLES = 16,
    parameter int DATA_WIDTH    = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  action,
    input  wire logic [31:0] operand_value,
    input  wire logic [3:0]  var_index,
    input  wire logic [3:0]  alu_op,
    input  wire logic [7:0]  label_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      write_value,
    output logic             write_valid,
    output logic             branch_taken,
    output logic [7:0]       branch_label,
    output logic [2:0]       status
);

    smeu_pkg::instr_t in_beat;
    smeu_pkg::instr_t q_data;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             in_fire;

    // Front part: pack the fields into one instruction beat.
    assign in_beat.action        = action;
    assign in_beat.operand_value = operand_value;
    assign in_beat.var_index     = var_index;
    assign in_beat.alu_op        = alu_op;
    assign in_beat.label_id      = label_id;
    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;

    smeu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (in_beat),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    smeu_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .NUM_VARIABLES (NUM_VARIABLES),
        .DATA_WIDTH    (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_value  (write_value),
        .write_valid  (write_valid),
        .branch_taken (branch_taken),
        .branch_label (branch_label),
        .status       (status)
    );

`ifndef SYNTHESIS
    // A written value only comes with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> status == smeu_pkg::ST_OK)
        else $error("write_valid with non-ok status");

    // Write and branch never report together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(write_valid && branch_taken))
        else $error("write and branch in one result");

    // The queue never pops when empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire
